// File: rtl/custom_isa_execute_unit_defines.svh
// assertion macros shared by the execute unit checker
// no dependencies; included by files that assert
`ifndef CUSTOM_ISA_EXECUTE_UNIT_DEFINES_SVH
`define CUSTOM_ISA_EXECUTE_UNIT_DEFINES_SVH

// implication in the same cycle, sampled on clk, off during reset
`define CIU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication into the next cycle
`define CIU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/ciu_pkg.sv
// types, codes and constants of the execute unit
// no dependencies
`default_nettype none
package ciu_pkg;

	localparam int MEM_BYTES = 4096;
	localparam int MEM_AW    = $clog2(MEM_BYTES);
	localparam int NBANK     = 8;
	localparam int ROWS      = MEM_BYTES / NBANK;
	localparam int ROW_W     = $clog2(ROWS);

	localparam logic [7:0] FLAG_REG = 8'hFF;
	localparam int ZERO_POS = 6;
	localparam int SIGN_POS = 7;
	localparam int HALT_POS = 15;

	localparam logic [3:0] FMT_RR  = 4'hA;
	localparam logic [3:0] FMT_RM  = 4'hB;
	localparam logic [3:0] FMT_MR  = 4'hC;
	localparam logic [3:0] FMT_IMM = 4'hD;
	localparam logic [3:0] FMT_FLG = 4'hF;

	localparam logic [7:0] OP_MOV  = 8'h01;
	localparam logic [7:0] OP_ADD  = 8'h02;
	localparam logic [7:0] OP_SUB  = 8'h03;
	localparam logic [7:0] OP_MUL  = 8'h04;
	localparam logic [7:0] OP_DIV  = 8'h05;
	localparam logic [7:0] OP_AND  = 8'h06;
	localparam logic [7:0] OP_OR   = 8'h07;
	localparam logic [7:0] OP_INC  = 8'h08;
	localparam logic [7:0] OP_DEC  = 8'h09;
	localparam logic [7:0] OP_SHL  = 8'h0A;
	localparam logic [7:0] OP_SHR  = 8'h0B;
	localparam logic [7:0] OP_HALT = 8'h0C;
	localparam logic [7:0] OP_CCLR = 8'h01;
	localparam logic [7:0] OP_CSET = 8'h02;
	localparam logic [7:0] OP_CCPL = 8'h03;
	localparam logic [7:0] OP_FLAST = 8'h0F;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_HALT    = 2'd1,
		ST_BAD     = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_EXEC, S_MULDIV, S_WB
	} state_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} md_req_t;

	typedef struct packed {
		logic       wr_reg;
		logic       wr_mem;
		logic       set_zn;
		logic       use_unit;
		logic       halt;
		logic       flag_op;
		status_t    status;
		logic [7:0] dst;
	} exec_ctl_t;

	// flag bit touched by the flag ops from direction clear onward
	function automatic logic [15:0] flag_mask(input logic [2:0] sel);
		case (sel)
			3'd1:    flag_mask = 16'h0001;
			3'd2:    flag_mask = 16'h0400;
			3'd3:    flag_mask = 16'h0200;
			3'd4:    flag_mask = 16'h0800;
			3'd5:    flag_mask = 16'h0080;
			3'd6:    flag_mask = 16'h0040;
			3'd7:    flag_mask = 16'h0004;
			default: flag_mask = 16'h0000;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: rtl/ciu_muldiv.sv
// shared radix-2 multiply / restoring divide unit, one bit per cycle
// depends on ciu_pkg
`default_nettype none
module ciu_muldiv import ciu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire md_req_t     req,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic             done,
	output logic [63:0]      result
);

	logic [6:0]  cnt_q;
	logic        done_q;
	logic        div_q;
	logic [63:0] acc_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [64:0] rem;
	logic        fits;

	assign rem  = {acc_q, x_q[63]};
	assign fits = rem >= {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == 7'd1);
			if (req.start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			x_q   <= a;
			y_q   <= b;
			div_q <= req.is_div;
		end else if (cnt_q != '0) begin
			if (div_q) begin
				// divide by zero falls out as all ones
				acc_q <= fits ? 64'(rem - {1'b0, y_q}) : rem[63:0];
				x_q   <= {x_q[62:0], fits};
			end else begin
				acc_q <= y_q[0] ? acc_q + x_q : acc_q;
				x_q   <= {x_q[62:0], 1'b0};
				y_q   <= {1'b0, y_q[63:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? x_q : acc_q;

endmodule
`default_nettype wire

// File: rtl/custom_isa_execute_unit.sv
// sequence from input transfer to result: accept, read, execute, write back
// multiply and divide pass through the shared bit-serial unit before write back
// one instruction at a time: the next is accepted only after the last is written back
// reset: register file reads as zero (per-entry valid bits), flags and halt cleared
// data memory has no reset and holds garbage until written
`default_nettype none
module custom_isa_execute_unit import ciu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // [63:0] instr_word
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata   // [1:0] status, [65:2] result_value,
	                                        // [81:66] flag_bits, [87:82] zero
);

	state_t state_q, state_d;

	// instruction held for the whole sequence
	logic [63:0] instr_q;
	logic [3:0]  fmt;
	logic [7:0]  op;
	logic [7:0]  s_idx, d_idx;
	assign fmt   = instr_q[63:60];
	assign op    = instr_q[59:52];
	assign s_idx = instr_q[51:44];
	assign d_idx = (fmt == FMT_RR) ? instr_q[43:36] : instr_q[19:12];

	// register file: 255 entries in memory, flag register in flops
	logic [63:0] rf_mem [256];
	logic [255:0] rf_vld_q;
	logic [63:0] flags_q;
	logic [63:0] rs_q, rd_q;
	logic        rs_vld_q, rd_vld_q;
	logic [63:0] rs_val, rd_val;

	// data memory: eight byte banks so an unaligned word hits each bank once
	logic [7:0]      dmem [NBANK][ROWS];
	logic [7:0]      mrd_q [NBANK];
	logic [MEM_AW-1:0] maddr;
	logic [ROW_W-1:0]  mrow [NBANK];
	logic [2:0]        mlane [NBANK];
	logic [63:0]       mval;

	// execute results
	exec_ctl_t   ctl, ctl_q;
	logic [63:0] opa, opb, res, res_q;
	logic [63:0] fnew, fnew_q;
	logic [63:0] res_wb, f_after;

	md_req_t     md_req;
	logic        md_done;
	logic [63:0] md_result;

	logic        out_valid_q;
	logic [87:0] out_data_q;
	logic        wb_fire;

	assign maddr = (fmt == FMT_RM) ? instr_q[12 +: MEM_AW] : instr_q[20 +: MEM_AW];

	always_comb begin
		for (int b = 0; b < NBANK; b++) begin
			logic [2:0]        lane;
			logic [MEM_AW:0]   sum;
			lane     = 3'(b) - maddr[2:0];
			sum      = {1'b0, maddr} + (MEM_AW + 1)'(lane);
			mlane[b] = lane;
			mrow[b]  = sum[MEM_AW-1:3];
		end
	end

	// little-endian word from the banks, starting at the addressed lane
	always_comb begin
		for (int i = 0; i < NBANK; i++) begin
			mval[8*i +: 8] = mrd_q[3'(maddr[2:0] + 3'(i))];
		end
	end

	assign rs_val = (s_idx == FLAG_REG) ? flags_q : (rs_vld_q ? rs_q : '0);
	assign rd_val = (d_idx == FLAG_REG) ? flags_q : (rd_vld_q ? rd_q : '0);

	// handshake
	assign s_axis_tready = (state_q == S_IDLE);
	assign wb_fire       = (state_q == S_WB) && (!out_valid_q || m_axis_tready);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		state_d = state_q;
		md_req  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_READ;
			end
			S_READ: begin
				state_d = S_EXEC;
			end
			S_EXEC: begin
				md_req.start  = ctl.use_unit;
				md_req.is_div = (op == OP_DIV);
				state_d       = ctl.use_unit ? S_MULDIV : S_WB;
			end
			S_MULDIV: begin
				if (md_done) state_d = S_WB;
			end
			S_WB: begin
				if (wb_fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// decode and combinational alu
	always_comb begin
		logic alu_op;
		alu_op = 1'b0;
		ctl    = '0;
		ctl.status = ST_DONE;
		ctl.dst    = d_idx;
		opa  = rs_val;
		opb  = rd_val;
		res  = '0;
		fnew = flags_q;
		if (flags_q[HALT_POS]) begin
			ctl.status = ST_IGNORED;
		end else begin
			unique case (fmt)
				FMT_RR: begin
					if (op == OP_MOV) begin
						res = rs_val;
						ctl.wr_reg = 1'b1;
					end else if (op == OP_INC || op == OP_DEC) begin
						res = (op == OP_INC) ? rd_val + 64'd1 : rd_val - 64'd1;
						ctl.wr_reg = 1'b1;
						ctl.set_zn = 1'b1;
					end else if (op == OP_HALT) begin
						ctl.halt   = 1'b1;
						ctl.status = ST_HALT;
					end else if (op == OP_SHL || op == OP_SHR) begin
						opa = rd_val;
						opb = rs_val;
						alu_op = 1'b1;
					end else if (op >= OP_ADD && op <= OP_OR) begin
						alu_op = 1'b1;
					end else begin
						ctl.status = ST_BAD;
					end
				end
				FMT_RM: begin
					ctl.dst = s_idx;
					if (op == OP_MOV) begin
						res = rs_val;
						ctl.wr_mem = 1'b1;
					end else if (op >= OP_ADD && op <= OP_DIV) begin
						opb = mval;
						alu_op = 1'b1;
						ctl.wr_mem = 1'b1;
					end else begin
						ctl.status = ST_BAD;
					end
				end
				FMT_MR: begin
					if (op == OP_MOV) begin
						res = mval;
						ctl.wr_reg = 1'b1;
					end else if (op >= OP_ADD && op <= OP_DIV) begin
						opa = mval;
						alu_op = 1'b1;
					end else begin
						ctl.status = ST_BAD;
					end
				end
				FMT_IMM: begin
					if (op == OP_MOV) begin
						res = {32'd0, instr_q[51:20]};
						ctl.wr_reg = 1'b1;
					end else if ((op >= OP_ADD && op <= OP_OR) || op == OP_SHL
						|| op == OP_SHR) begin
						opa = rd_val;
						opb = {32'd0, instr_q[51:20]};
						alu_op = 1'b1;
					end else begin
						ctl.status = ST_BAD;
					end
				end
				FMT_FLG: begin
					ctl.flag_op = 1'b1;
					if (op == OP_CCLR) begin
						fnew[0] = 1'b0;
					end else if (op == OP_CSET) begin
						fnew[0] = 1'b1;
					end else if (op == OP_CCPL) begin
						fnew[0] = ~flags_q[0];
					end else if (op > OP_CCPL && op <= OP_FLAST) begin
						if (op[0]) fnew[15:0] = flags_q[15:0] | flag_mask(op[3:1]);
						else       fnew[15:0] = flags_q[15:0] & ~flag_mask(op[3:1]);
					end else begin
						ctl.status = ST_BAD;
					end
				end
				default: ctl.status = ST_BAD;
			endcase
		end
		if (alu_op) begin
			ctl.wr_reg   = 1'b1;
			ctl.set_zn   = 1'b1;
			ctl.use_unit = (op == OP_MUL) || (op == OP_DIV);
			case (op)
				OP_ADD:  res = opa + opb;
				OP_SUB:  res = opa - opb;
				OP_AND:  res = opa & opb;
				OP_OR:   res = opa | opb;
				OP_SHL:  res = (opb >= 64'd64) ? '0 : opa << opb[5:0];
				OP_SHR:  res = (opb >= 64'd64) ? '0 : opa >> opb[5:0];
				default: res = '0;
			endcase
		end
	end

	// write-back value and final flags; flag update comes after the register write
	assign res_wb = ctl_q.use_unit ? md_result : res_q;

	always_comb begin
		f_after = flags_q;
		if (ctl_q.flag_op && ctl_q.status == ST_DONE) f_after = fnew_q;
		if (ctl_q.wr_reg && ctl_q.dst == FLAG_REG) f_after = res_wb;
		if (ctl_q.set_zn) begin
			f_after[ZERO_POS] = (res_wb == '0);
			f_after[SIGN_POS] = res_wb[63];
		end
		if (ctl_q.halt) f_after[HALT_POS] = 1'b1;
	end

	ciu_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.a      (opa),
		.b      (opb),
		.done   (md_done),
		.result (md_result)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rf_vld_q    <= '0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wb_fire) begin
				flags_q <= f_after;
				if (ctl_q.wr_reg && ctl_q.dst != FLAG_REG) rf_vld_q[ctl_q.dst] <= 1'b1;
			end
			if (wb_fire) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// payload and pipeline registers
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) instr_q <= s_axis_tdata;
		if (state_q == S_READ) begin
			rs_vld_q <= rf_vld_q[s_idx];
			rd_vld_q <= rf_vld_q[d_idx];
		end
		if (state_q == S_EXEC) begin
			ctl_q  <= ctl;
			res_q  <= res;
			fnew_q <= fnew;
		end
		if (wb_fire) begin
			out_data_q <= {6'd0, f_after[15:0], res_wb, ctl_q.status};
		end
	end

	// register file memory, two read ports and one write port
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rs_q <= rf_mem[s_idx];
			rd_q <= rf_mem[d_idx];
		end
		if (wb_fire && ctl_q.wr_reg && ctl_q.dst != FLAG_REG) rf_mem[ctl_q.dst] <= res_wb;
	end

	// data memory banks, read in the read state, written at write back
	always_ff @(posedge clk) begin
		for (int b = 0; b < NBANK; b++) begin
			if (state_q == S_READ) mrd_q[b] <= dmem[b][mrow[b]];
			if (wb_fire && ctl_q.wr_mem) dmem[b][mrow[b]] <= res_wb[8*mlane[b] +: 8];
		end
	end

endmodule
`default_nettype wire

// File: rtl/ciu_checker.sv
// port-level checks on the execute unit, bound to the top level
// depends on ciu_pkg and custom_isa_execute_unit_defines.svh
`default_nettype none
`include "custom_isa_execute_unit_defines.svh"
module ciu_checker import ciu_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [87:0] m_axis_tdata
);

	// result held until taken
	`CIU_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// one instruction at a time
	`CIU_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// halt and ignored results show the halt flag
	`CIU_ASSERT_IMP(a_halt_flag, m_axis_tvalid && (m_axis_tdata[1:0] == ST_HALT || m_axis_tdata[1:0] == ST_IGNORED), m_axis_tdata[81])
	// rejected, ignored and halt results carry a zero result value
	`CIU_ASSERT_IMP(a_bad_zero, m_axis_tvalid && (m_axis_tdata[1:0] == ST_BAD || m_axis_tdata[1:0] == ST_IGNORED || m_axis_tdata[1:0] == ST_HALT), m_axis_tdata[65:2] == 64'd0)

endmodule

bind custom_isa_execute_unit ciu_checker u_ciu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
